/* rtl/mag_hard_iron_tilt_angles_core_assert.svh */
// assertion macros included by the rtl datapath
`ifndef MAG_HARD_IRON_TILT_ANGLES_CORE_ASSERT_SVH
`define MAG_HARD_IRON_TILT_ANGLES_CORE_ASSERT_SVH
// implication checked every clock, disabled in reset
`define MHI_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define MHI_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* rtl/mhi_pkg.sv */
// shared types and constants of the hard-iron and angle block
package mhi_pkg;
  localparam int StepCount = 19;
  localparam int WorkBits  = 16;
  localparam int IterBits  = 5;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_SQRT,
    ST_LOAD,
    ST_ITER,
    ST_ROUND,
    ST_OUT
  } state_e;

  // angle job selection
  typedef enum logic [1:0] {
    JOB_RAW,
    JOB_COR,
    JOB_TA,
    JOB_TB
  } job_e;

  // commands from controller to datapath
  typedef struct packed {
    logic in_take;
    logic track;
    logic sqrt_init;
    logic sqrt_step;
    logic load;
    logic iter;
    logic round;
    job_e job;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sqrt_done;
    logic iter_done;
  } sts_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [22:0] atan_step(input logic [IterBits-1:0] i);
    case (i)
      5'd0:  atan_step = 23'd2949120;
      5'd1:  atan_step = 23'd1740967;
      5'd2:  atan_step = 23'd919879;
      5'd3:  atan_step = 23'd466945;
      5'd4:  atan_step = 23'd234379;
      5'd5:  atan_step = 23'd117304;
      5'd6:  atan_step = 23'd58666;
      5'd7:  atan_step = 23'd29335;
      5'd8:  atan_step = 23'd14668;
      5'd9:  atan_step = 23'd7334;
      5'd10: atan_step = 23'd3667;
      5'd11: atan_step = 23'd1833;
      5'd12: atan_step = 23'd917;
      5'd13: atan_step = 23'd458;
      5'd14: atan_step = 23'd229;
      5'd15: atan_step = 23'd115;
      5'd16: atan_step = 23'd57;
      5'd17: atan_step = 23'd29;
      5'd18: atan_step = 23'd14;
      default: atan_step = 23'd0;
    endcase
  endfunction
endpackage

/* rtl/mhi_ctrl.sv */
// controller sequencing tracking, square root and four cordic runs
module mhi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mhi_pkg::sts_t sts_i,
  output mhi_pkg::cmd_t cmd_o
);
  mhi_pkg::state_e state_q, state_d;
  mhi_pkg::job_e   job_q, job_d;

  // next state
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    case (state_q)
      mhi_pkg::ST_IDLE:  if (in_valid_i) state_d = mhi_pkg::ST_TRACK;
      mhi_pkg::ST_TRACK: state_d = mhi_pkg::ST_SQRT;
      mhi_pkg::ST_SQRT: begin
        if (sts_i.sqrt_done) begin
          state_d = mhi_pkg::ST_LOAD;
          job_d   = mhi_pkg::JOB_RAW;
        end
      end
      mhi_pkg::ST_LOAD:  state_d = mhi_pkg::ST_ITER;
      mhi_pkg::ST_ITER:  if (sts_i.iter_done) state_d = mhi_pkg::ST_ROUND;
      mhi_pkg::ST_ROUND: begin
        if (job_q == mhi_pkg::JOB_TB) begin
          state_d = mhi_pkg::ST_OUT;
        end else begin
          state_d = mhi_pkg::ST_LOAD;
          job_d   = mhi_pkg::job_e'(job_q + 2'd1);
        end
      end
      mhi_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = mhi_pkg::ST_IDLE;
      end
      default: state_d = mhi_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.job       = job_q;
    in_stall_o      = (state_q != mhi_pkg::ST_IDLE);
    out_valid_o     = (state_q == mhi_pkg::ST_OUT);
    cmd_o.in_take   = (state_q == mhi_pkg::ST_IDLE) && in_valid_i;
    cmd_o.track     = (state_q == mhi_pkg::ST_TRACK);
    cmd_o.sqrt_init = (state_q == mhi_pkg::ST_TRACK);
    cmd_o.sqrt_step = (state_q == mhi_pkg::ST_SQRT);
    cmd_o.load      = (state_q == mhi_pkg::ST_LOAD);
    cmd_o.iter      = (state_q == mhi_pkg::ST_ITER);
    cmd_o.round     = (state_q == mhi_pkg::ST_ROUND);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhi_pkg::ST_IDLE;
      job_q   <= mhi_pkg::JOB_RAW;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end
endmodule

/* rtl/mhi_datapath.sv */
// datapath: min/max tracking, bit-serial square root, shared cordic
module mhi_datapath #(
  parameter int SampleBits = 16,
  parameter int AngleFracBits = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mhi_pkg::cmd_t                 cmd_i,
  output mhi_pkg::sts_t                 sts_o,
  input  logic signed [SampleBits-1:0]  accel_x_i,
  input  logic signed [SampleBits-1:0]  accel_y_i,
  input  logic signed [SampleBits-1:0]  accel_z_i,
  input  logic signed [SampleBits-1:0]  field_x_i,
  input  logic signed [SampleBits-1:0]  field_y_i,
  input  logic signed [SampleBits-1:0]  field_z_i,
  output logic signed [8+AngleFracBits:0] heading_raw_o,
  output logic signed [8+AngleFracBits:0] heading_corrected_o,
  output logic signed [8+AngleFracBits:0] tilt_a_o,
  output logic signed [7+AngleFracBits:0] tilt_b_o,
  output logic signed [SampleBits-1:0]  offset_x_o,
  output logic signed [SampleBits-1:0]  offset_y_o,
  output logic signed [SampleBits-1:0]  offset_z_o,
  output logic signed [SampleBits:0]    corrected_x_o,
  output logic signed [SampleBits:0]    corrected_y_o,
  output logic signed [SampleBits:0]    corrected_z_o
);
  localparam int SB = SampleBits;
  localparam int AW = 9 + AngleFracBits;
  // operand width: up to sb+2 signed, scaled and grown by cordic gain
  localparam int OW = SB + 2;
  localparam int CW = OW + mhi_pkg::WorkBits + 2;
  localparam int ZW = 26;
  localparam int SQW = 2 * SB;
  localparam int RW = SB + 1;
  localparam int SqIters = SB;
  localparam int SqCntW = $clog2(SqIters + 1);
  localparam int RShift = mhi_pkg::WorkBits - AngleFracBits;
  localparam logic signed [ZW-1:0] Z90 = ZW'(90 * (1 << mhi_pkg::WorkBits));
  localparam logic signed [ZW-1:0] HalfLsb = ZW'(1 << (RShift - 1));

  // captured sample
  logic signed [SB-1:0] ax_q, ay_q, az_q, fx_q, fy_q, fz_q;
  logic signed [SB-1:0] mx_q [3];
  logic signed [SB-1:0] mn_q [3];
  logic signed [SB-1:0] off_q [3];
  logic signed [SB:0]   cor_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      ax_q <= accel_x_i; ay_q <= accel_y_i; az_q <= accel_z_i;
      fx_q <= field_x_i; fy_q <= field_y_i; fz_q <= field_z_i;
    end
  end

  // running extremes and offsets
  logic signed [SB-1:0] fld [3];
  logic signed [SB-1:0] nmx [3];
  logic signed [SB-1:0] nmn [3];
  logic signed [SB:0]   msum [3];
  logic signed [SB-1:0] noff [3];
  always_comb begin
    fld[0] = fx_q; fld[1] = fy_q; fld[2] = fz_q;
    for (int k = 0; k < 3; k++) begin
      nmx[k]  = (fld[k] > mx_q[k]) ? fld[k] : mx_q[k];
      nmn[k]  = (fld[k] < mn_q[k]) ? fld[k] : mn_q[k];
      msum[k] = (SB+1)'(nmx[k]) + (SB+1)'(nmn[k]);
      noff[k] = msum[k][SB:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        mx_q[k] <= {1'b1, {(SB-1){1'b0}}};
        mn_q[k] <= {1'b0, {(SB-1){1'b1}}};
      end
    end else if (cmd_i.track) begin
      for (int k = 0; k < 3; k++) begin
        mx_q[k] <= nmx[k];
        mn_q[k] <= nmn[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.track) begin
      for (int k = 0; k < 3; k++) begin
        off_q[k] <= noff[k];
        cor_q[k] <= (SB+1)'(fld[k]) - (SB+1)'(noff[k]);
      end
    end
  end

  // bit-serial square root, one result bit a cycle
  logic [SQW-1:0]    sq_n_q;
  logic [RW:0]       sq_r_q;
  logic [SQW+1:0]    sq_rem_q;
  logic [SqCntW-1:0] sq_cnt_q;
  logic [SQW+1:0]    sq_rem_sh, sq_trial;
  logic signed [SQW-1:0] ay_w, az_w;
  logic [SQW-1:0]    ay2, az2;
  // squares formed at full product width
  assign ay_w = SQW'(ay_q);
  assign az_w = SQW'(az_q);
  assign ay2 = $unsigned(ay_w * ay_w);
  assign az2 = $unsigned(az_w * az_w);
  always_comb begin
    sq_rem_sh = {sq_rem_q[SQW-1:0], sq_n_q[SQW-1 -: 2]};
    sq_trial  = sq_rem_sh - (SQW+2)'({sq_r_q, 2'b01});
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_n_q   <= SQW'(ay2 + az2);
      sq_r_q   <= '0;
      sq_rem_q <= '0;
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_n_q   <= {sq_n_q[SQW-3:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + 1'b1;
      if (!sq_trial[SQW+1]) begin
        sq_rem_q <= sq_trial;
        sq_r_q   <= {sq_r_q[RW-1:0], 1'b1};
      end else begin
        sq_rem_q <= sq_rem_sh;
        sq_r_q   <= {sq_r_q[RW-1:0], 1'b0};
      end
    end
  end
  assign sts_o.sqrt_done = cmd_i.sqrt_step && (sq_cnt_q == SqCntW'(SqIters - 1));

  // operand selection for the current angle job
  logic signed [OW-1:0] op_y, op_x;
  always_comb begin
    case (cmd_i.job)
      mhi_pkg::JOB_RAW: begin
        op_y = -OW'(fy_q); op_x = OW'(fx_q);
      end
      mhi_pkg::JOB_COR: begin
        op_y = -OW'(cor_q[1]); op_x = OW'(cor_q[0]);
      end
      mhi_pkg::JOB_TA: begin
        op_y = OW'(ay_q); op_x = OW'(az_q);
      end
      default: begin
        op_y = -OW'(ax_q); op_x = OW'($signed({1'b0, sq_r_q[RW-1:0]}));
      end
    endcase
  end

  // cordic vectoring, one step a cycle
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] cz_q;
  logic [mhi_pkg::IterBits-1:0] it_q;
  logic                 zero_q;
  logic signed [CW-1:0] cx_sh, cy_sh;
  logic signed [ZW-1:0] tstep;
  logic signed [OW-1:0] pre_x, pre_y;
  logic signed [ZW-1:0] pre_z;
  always_comb begin
    pre_x = op_x; pre_y = op_y; pre_z = '0;
    if (op_x < 0) begin
      if (op_y >= 0) begin
        pre_x = op_y; pre_y = -op_x; pre_z = Z90;
      end else begin
        pre_x = -op_y; pre_y = op_x; pre_z = -Z90;
      end
    end
    cx_sh = cx_q >>> it_q;
    cy_sh = cy_q >>> it_q;
    tstep = ZW'($signed({1'b0, mhi_pkg::atan_step(it_q)}));
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q   <= CW'(pre_x) <<< mhi_pkg::WorkBits;
      cy_q   <= CW'(pre_y) <<< mhi_pkg::WorkBits;
      cz_q   <= pre_z;
      it_q   <= '0;
      zero_q <= (op_x == 0) && (op_y == 0);
    end else if (cmd_i.iter) begin
      it_q <= it_q + 1'b1;
      if (cy_q > 0) begin
        cx_q <= cx_q + cy_sh; cy_q <= cy_q - cx_sh; cz_q <= cz_q + tstep;
      end else if (cy_q < 0) begin
        cx_q <= cx_q - cy_sh; cy_q <= cy_q + cx_sh; cz_q <= cz_q - tstep;
      end
    end
  end
  assign sts_o.iter_done = cmd_i.iter &&
                           (it_q == mhi_pkg::IterBits'(mhi_pkg::StepCount - 1));

  // rounding and saturation
  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] lim;
  logic signed [ZW-1:0] ang;
  always_comb begin
    zr  = (cz_q + HalfLsb) >>> RShift;
    lim = (cmd_i.job == mhi_pkg::JOB_TB) ? ZW'(90 << AngleFracBits)
                                         : ZW'(180 << AngleFracBits);
    ang = zr;
    if (zr > lim) ang = lim;
    if (zr < -lim) ang = -lim;
    if (zero_q) ang = '0;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      case (cmd_i.job)
        mhi_pkg::JOB_RAW: heading_raw_o       <= ang[AW-1:0];
        mhi_pkg::JOB_COR: heading_corrected_o <= ang[AW-1:0];
        mhi_pkg::JOB_TA:  tilt_a_o            <= ang[AW-1:0];
        default:          tilt_b_o            <= ang[AW-2:0];
      endcase
    end
  end

  assign offset_x_o = off_q[0];
  assign offset_y_o = off_q[1];
  assign offset_z_o = off_q[2];
  assign corrected_x_o = cor_q[0];
  assign corrected_y_o = cor_q[1];
  assign corrected_z_o = cor_q[2];

`include "mag_hard_iron_tilt_angles_core_assert.svh"
  // tracked maximum never falls
  `MHI_ASSERT_NXT(a_max_mono, clk_i, rst_ni, cmd_i.track, mx_q[0] >= $past(mx_q[0]))
  // after tracking the offset lies between minimum and maximum
  `MHI_ASSERT_NXT(a_off_range, clk_i, rst_ni, cmd_i.track,
                  off_q[0] <= mx_q[0] && off_q[0] >= mn_q[0])
  // cordic counter stays within its run
  `MHI_ASSERT_IMP(a_iter_range, clk_i, rst_ni, cmd_i.iter,
                  it_q < mhi_pkg::IterBits'(mhi_pkg::StepCount))
endmodule

/* rtl/mag_hard_iron_tilt_angles_core.sv */
// top level of the magnetometer hard-iron calibration and angle block
// One sample at a time: the block takes a request while idle, then runs
// min/max tracking, the bit-serial square root over SampleBits result bits
// and four runs of the shared one-step-per-cycle cordic (load, 19 steps,
// round), then presents the result and holds it until taken. New requests
// stall until then; most of the work falls to the single shared cordic.
module mag_hard_iron_tilt_angles_core #(
  parameter int SampleBits = 16,
  parameter int AngleFracBits = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SampleBits-1:0]    accel_x_i,
  input  logic signed [SampleBits-1:0]    accel_y_i,
  input  logic signed [SampleBits-1:0]    accel_z_i,
  input  logic signed [SampleBits-1:0]    field_x_i,
  input  logic signed [SampleBits-1:0]    field_y_i,
  input  logic signed [SampleBits-1:0]    field_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [8+AngleFracBits:0] heading_raw_o,
  output logic signed [8+AngleFracBits:0] heading_corrected_o,
  output logic signed [8+AngleFracBits:0] tilt_a_o,
  output logic signed [7+AngleFracBits:0] tilt_b_o,
  output logic signed [SampleBits-1:0]    offset_x_o,
  output logic signed [SampleBits-1:0]    offset_y_o,
  output logic signed [SampleBits-1:0]    offset_z_o,
  output logic signed [SampleBits:0]      corrected_x_o,
  output logic signed [SampleBits:0]      corrected_y_o,
  output logic signed [SampleBits:0]      corrected_z_o
);
  mhi_pkg::cmd_t cmd;
  mhi_pkg::sts_t sts;

  // sequencer
  mhi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // arithmetic
  mhi_datapath #(.SampleBits(SampleBits), .AngleFracBits(AngleFracBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .accel_x_i, .accel_y_i, .accel_z_i, .field_x_i, .field_y_i, .field_z_i,
    .heading_raw_o, .heading_corrected_o, .tilt_a_o, .tilt_b_o,
    .offset_x_o, .offset_y_o, .offset_z_o,
    .corrected_x_o, .corrected_y_o, .corrected_z_o
  );
endmodule

/* sim/tb_mag_hard_iron_tilt_angles_core.sv */
// testbench for the magnetometer hard-iron calibration and angle block
`timescale 1ns / 100ps

module tb_mag_hard_iron_tilt_angles_core;

  localparam int NumRandom = 1000;

  // one imu sample
  typedef struct {
    logic signed [15:0] ax, ay, az, fx, fy, fz;
  } imu_sample_t;

  // one set of block outputs
  typedef struct {
    logic signed [14:0] hdg_raw, hdg_cor, tilt_a;
    logic signed [13:0] tilt_b;
    logic signed [15:0] off_x, off_y, off_z;
    logic signed [16:0] cor_x, cor_y, cor_z;
  } angle_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] field_x_i = '0, field_y_i = '0, field_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [14:0] heading_raw_o, heading_corrected_o, tilt_a_o;
  logic signed [13:0] tilt_b_o;
  logic signed [15:0] offset_x_o, offset_y_o, offset_z_o;
  logic signed [16:0] corrected_x_o, corrected_y_o, corrected_z_o;

  imu_sample_t   pending_samples[$];
  angle_result_t expected_angles[$];
  longint        track_max[3];
  longint        track_min[3];
  int            errors = 0;
  bit            stim_done = 1'b0;
  bit            in_taken = 1'b0;
  int            idle_left = 0;
  int            hold_off = 0;
  int            rx_count = 0;

  mag_hard_iron_tilt_angles_core u_dut (.*);

  always #5 clk_i = ~clk_i;

  // arithmetic shift right with floor
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  // cordic vectoring angle in 2^-6 degree, saturated to +-lim degrees
  function automatic longint cordic_angle(longint y, longint x, longint lim);
    longint z, t, nx, ny, r;
    longint steps[19] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < 19; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i); ny = y - shr_floor(x, i); z += steps[i];
        x = nx; y = ny;
      end else if (y < 0) begin
        nx = x - shr_floor(y, i); ny = y + shr_floor(x, i); z -= steps[i];
        x = nx; y = ny;
      end
    end
    r = shr_floor(z + 512, 10);
    if (r > lim * 64) r = lim * 64;
    if (r < -lim * 64) r = -lim * 64;
    return r;
  endfunction

  // floor of integer square root
  function automatic longint int_sqrt(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >>> 1) + bit_v;
      end else begin
        res >>>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // update min/max tracking and compute the expected outputs
  function automatic angle_result_t predict_angles(imu_sample_t s);
    angle_result_t e;
    longint m[3], off[3], cor[3], ay, az;
    m[0] = s.fx; m[1] = s.fy; m[2] = s.fz;
    for (int k = 0; k < 3; k++) begin
      if (m[k] > track_max[k]) track_max[k] = m[k];
      if (m[k] < track_min[k]) track_min[k] = m[k];
      off[k] = shr_floor(track_max[k] + track_min[k], 1);
      cor[k] = m[k] - off[k];
    end
    ay = s.ay;
    az = s.az;
    e.hdg_raw = 15'(cordic_angle(-m[1], m[0], 180));
    e.hdg_cor = 15'(cordic_angle(-cor[1], cor[0], 180));
    e.tilt_a  = 15'(cordic_angle(ay, az, 180));
    e.tilt_b  = 14'(cordic_angle(-longint'(s.ax), int_sqrt(ay * ay + az * az), 90));
    e.off_x = 16'(off[0]); e.off_y = 16'(off[1]); e.off_z = 16'(off[2]);
    e.cor_x = 17'(cor[0]); e.cor_y = 17'(cor[1]); e.cor_z = 17'(cor[2]);
    return e;
  endfunction

  // random axis value weighted toward extremes and small values
  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t make_sample(int ax, int ay, int az, int fx, int fy, int fz);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.fx = 16'(fx); s.fy = 16'(fy); s.fz = 16'(fz);
    return s;
  endfunction

  // stimulus: directed corner cases then random samples
  initial begin
    imu_sample_t s;
    for (int k = 0; k < 3; k++) begin
      track_max[k] = -32768;
      track_min[k] = 32767;
    end
    // zero vectors everywhere
    pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0));
    // negative x with zero y gives +180
    pending_samples.push_back(make_sample(0, 0, -100, -100, 0, 5));
    pending_samples.push_back(make_sample(-32768, 0, -32768, -32768, 0, -32768));
    pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(make_sample(32767, -32768, 0, 0, -32768, 32767));
    pending_samples.push_back(make_sample(-32768, 0, 0, 0, 32767, 0));
    pending_samples.push_back(make_sample(1, -1, -1, -1, -1, 1));
    pending_samples.push_back(make_sample(-1, 1, 0, 1, 1, -1));
    pending_samples.push_back(make_sample(0, -32768, 1, -32768, -1, 0));
    pending_samples.push_back(make_sample(5, 3, 4, -3, 4, 12));
    pending_samples.push_back(make_sample(-300, 200, -100, 300, -300, 7));
    for (int n = 0; n < NumRandom; n++) begin
      s.ax = rand_axis(); s.ay = rand_axis(); s.az = rand_axis();
      s.fx = rand_axis(); s.fy = rand_axis(); s.fz = rand_axis();
      pending_samples.push_back(s);
    end
  end

  // reset sequence
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // request acceptance seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_angles.push_back(predict_angles(pending_samples.pop_front()));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    imu_sample_t s;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (idle_left > 0) begin
          idle_left <= idle_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0 && $urandom_range(0, 3) != 0) begin
          s = pending_samples[0];
          in_valid_i <= 1'b1;
          accel_x_i <= s.ax; accel_y_i <= s.ay; accel_z_i <= s.az;
          field_x_i <= s.fx; field_y_i <= s.fy; field_z_i <= s.fz;
        end else begin
          in_valid_i <= 1'b0;
          if ($urandom_range(0, 49) == 0) idle_left <= $urandom_range(20, 100);
          if (pending_samples.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else if (rx_count == 20 && out_stall_i == 1'b0) begin
      hold_off <= 600;
      out_stall_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: out_stall_i <= 1'b1;
        1, 2, 3: out_stall_i <= ($urandom_range(0, 1) == 1);
        default: out_stall_i <= (rx_count % 200 < 100) ? 1'b0 : ($urandom_range(0, 1) == 1);
      endcase
      if ($urandom_range(0, 99) == 0) hold_off <= $urandom_range(50, 200);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    angle_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rx_count <= rx_count + 1;
      if (expected_angles.size() == 0) begin
        $display("%0t: unexpected result, heading_raw actual %0d", $realtime, heading_raw_o);
        errors++;
      end else begin
        e = expected_angles.pop_front();
        if (heading_raw_o !== e.hdg_raw) begin
          $display("%0t: heading_raw expected %0d actual %0d", $realtime, e.hdg_raw,
                   heading_raw_o);
          errors++;
        end
        if (heading_corrected_o !== e.hdg_cor) begin
          $display("%0t: heading_corrected expected %0d actual %0d", $realtime, e.hdg_cor,
                   heading_corrected_o);
          errors++;
        end
        if (tilt_a_o !== e.tilt_a) begin
          $display("%0t: tilt_a expected %0d actual %0d", $realtime, e.tilt_a, tilt_a_o);
          errors++;
        end
        if (tilt_b_o !== e.tilt_b) begin
          $display("%0t: tilt_b expected %0d actual %0d", $realtime, e.tilt_b, tilt_b_o);
          errors++;
        end
        if ({offset_x_o, offset_y_o, offset_z_o} !== {e.off_x, e.off_y, e.off_z}) begin
          $display("%0t: offsets expected %0d %0d %0d actual %0d %0d %0d", $realtime,
                   e.off_x, e.off_y, e.off_z, offset_x_o, offset_y_o, offset_z_o);
          errors++;
        end
        if ({corrected_x_o, corrected_y_o, corrected_z_o} !== {e.cor_x, e.cor_y, e.cor_z})
        begin
          $display("%0t: corrected expected %0d %0d %0d actual %0d %0d %0d", $realtime,
                   e.cor_x, e.cor_y, e.cor_z, corrected_x_o, corrected_y_o, corrected_z_o);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && expected_angles.size() == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/mhi_pkg.sv
rtl/mhi_ctrl.sv
rtl/mhi_datapath.sv
rtl/mag_hard_iron_tilt_angles_core.sv
sim/tb_mag_hard_iron_tilt_angles_core.sv
